// File: hw/rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg: shared types and constants for the BMP stream pixel decoder
// Item types for both channels, queue entry type, parse phases, header
// byte positions and result codes.
// ----------------------------------------------------------------------------
package bmpd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int DIM_MAX    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W      = $clog2(DIM_MAX + 1);
	localparam int IDX_W      = 20;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [31:0] POS_OFFSET_LAST = 32'd13;
	localparam logic [31:0] POS_WIDTH_LAST  = 32'd21;
	localparam logic [31:0] POS_HEIGHT_LAST = 32'd25;
	localparam logic [31:0] POS_DEPTH_LAST  = 32'd29;
	localparam logic [31:0] POS_HEADER_LAST = 32'd53;
	localparam logic [31:0] POS_SATURATED   = 32'hFFFF_FFFF;

	localparam logic [15:0] BPP_32 = 16'd32;
	localparam logic [15:0] BPP_24 = 16'd24;

	localparam logic [1:0] LANE_TOP_32 = 2'd3;
	localparam logic [1:0] LANE_TOP_24 = 2'd2;
	localparam logic [3:0] MASK_32     = 4'hF;
	localparam logic [3:0] MASK_24     = 4'h7;

	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd1;
	localparam logic [1:0] ST_TOO_BIG   = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] pixel_index;
		logic [31:0]      pixel_value;
		logic [3:0]       lane_mask;
		logic             last_pixel;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] width;
		logic [31:0]      value;
		logic [3:0]       lane_mask;
		logic             last_pixel;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} push_t;

	typedef struct packed {
		logic    nonempty;
		qentry_t entry;
	} head_t;

endpackage

// File: hw/rtl/bmp_stream_pixel_decoder.sv
// ----------------------------------------------------------------------------
// bmp_stream_pixel_decoder: streaming BMP decoder, 24 and 32 bpp
// Parses the header from a byte stream, skips to the pixel data and emits
// one framebuffer write per pixel, or one error result per bad header.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+---------------------------------
//   bytes    | file_valid  | file_stall  | file_data  (in_item_t)
//   pixels   | pixel_valid | pixel_stall | pixel_data (out_item_t)
//
// One byte is taken every cycle while file_stall is low; a result passes through
// the queue write and the output register that holds the computed index before
// it is offered.
// file_stall rises only while the four-entry queue is full, which happens
// when pixel_stall holds results back.
// Reset clears all parse state; the first byte after reset is file byte 0.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                file_valid,
	output logic                file_stall,
	input  bmpd_pkg::in_item_t  file_data,
	output logic                pixel_valid,
	input  logic                pixel_stall,
	output bmpd_pkg::out_item_t pixel_data
);
	import bmpd_pkg::*;

	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;

	bmpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.file_stall (file_stall),
		.file_data  (file_data),
		.q_full     (q_full),
		.push       (push)
	);

	bmpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	bmpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_data  (pixel_data)
	);

endmodule

// File: hw/rtl/bmpd_front.sv
// ----------------------------------------------------------------------------
// bmpd_front: header parser and pixel assembler
// Takes one file byte per cycle unless the queue is full, tracks header fields,
// offset skip, row padding and pixel counters, and pushes finished requests to the queue.
// ----------------------------------------------------------------------------
module bmpd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               file_valid,
	output logic               file_stall,
	input  bmpd_pkg::in_item_t file_data,
	input  logic               q_full,
	output bmpd_pkg::push_t    push
);
	import bmpd_pkg::*;

	logic [31:0]      pos_q, hshift_q, offset_q;
	logic [DIM_W-1:0] width_q, height_q, row_q, col_q;
	logic             wbig_q, hbig_q, depth32_q;
	phase_t           phase_q;
	logic [1:0]       lane_q, rbc_q;
	logic [31:0]      asm_q;

	logic [31:0]      pos_c, hshift_c, offset_c;
	logic [DIM_W-1:0] width_c, height_c, row_c, col_c;
	logic             wbig_c, hbig_c, depth32_c;
	phase_t           phase_c;
	logic [1:0]       lane_c, rbc_c;
	logic [31:0]      asm_c;

	logic [31:0]      pos_n, hshift_n, offset_n;
	logic [DIM_W-1:0] width_n, height_n, row_n, col_n;
	logic             wbig_n, hbig_n, depth32_n;
	phase_t           phase_n;
	logic [1:0]       lane_n, rbc_n;
	logic [31:0]      asm_n;

	logic             accept, start;
	logic [7:0]       b;
	logic [31:0]      hs_new, asm_new;
	logic [15:0]      bpp;
	logic             depth_ok, size_bad, empty_img, in_pixel, pad, pix_done;
	logic             row_end, last;
	logic [1:0]       lane_top, lane_sel;
	logic [DIM_W:0]   col_inc;
	logic             push_c;
	qentry_t          entry_c;

	assign start      = file_data.file_start;
	assign b          = file_data.file_byte;
	assign file_stall = q_full;
	assign accept     = file_valid && !q_full;

	always_comb begin
		if (start) begin
			pos_c     = '0;
			hshift_c  = '0;
			offset_c  = '0;
			width_c   = '0;
			height_c  = '0;
			wbig_c    = 1'b0;
			hbig_c    = 1'b0;
			depth32_c = 1'b0;
			phase_c   = PH_HEADER;
			row_c     = '0;
			col_c     = '0;
			lane_c    = '0;
			rbc_c     = '0;
			asm_c     = '0;
		end else begin
			pos_c     = pos_q;
			hshift_c  = hshift_q;
			offset_c  = offset_q;
			width_c   = width_q;
			height_c  = height_q;
			wbig_c    = wbig_q;
			hbig_c    = hbig_q;
			depth32_c = depth32_q;
			phase_c   = phase_q;
			row_c     = row_q;
			col_c     = col_q;
			lane_c    = lane_q;
			rbc_c     = rbc_q;
			asm_c     = asm_q;
		end
	end

	assign hs_new    = {b, hshift_c[31:8]};
	assign bpp       = hs_new[31:16];
	assign depth_ok  = (bpp == BPP_32) || (bpp == BPP_24);
	assign size_bad  = wbig_c || hbig_c;
	assign empty_img = (width_c == '0) || (height_c == '0);
	assign in_pixel  = (phase_c == PH_PIXEL) || ((phase_c == PH_SKIP) && (pos_c >= offset_c));
	assign pad       = (col_c == '0) && (lane_c == 2'd0) && (rbc_c != 2'd0);
	assign lane_top  = depth32_c ? LANE_TOP_32 : LANE_TOP_24;
	assign lane_sel  = lane_top - lane_c;
	assign asm_new   = asm_c | (32'(b) << {lane_sel, 3'b000});
	assign pix_done  = in_pixel && !pad && (lane_c == lane_top);
	assign col_inc   = {1'b0, col_c} + 1'b1;
	assign row_end   = (col_inc == {1'b0, width_c});
	assign last      = row_end && (row_c == '0);

	always_comb begin
		phase_n = phase_c;
		case (phase_c)
			PH_HEADER: begin
				if (pos_c == POS_DEPTH_LAST) begin
					if (size_bad || !depth_ok) phase_n = PH_DONE;
				end else if (pos_c == POS_HEADER_LAST) begin
					phase_n = empty_img ? PH_DONE : PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (in_pixel) phase_n = PH_PIXEL;
			end
			PH_PIXEL: begin
				if (pix_done && last) phase_n = PH_DONE;
			end
			default: phase_n = phase_c;
		endcase
	end

	always_comb begin
		pos_n     = (pos_c == POS_SATURATED) ? pos_c : pos_c + 32'd1;
		hshift_n  = hshift_c;
		offset_n  = offset_c;
		width_n   = width_c;
		height_n  = height_c;
		wbig_n    = wbig_c;
		hbig_n    = hbig_c;
		depth32_n = depth32_c;
		row_n     = row_c;
		col_n     = col_c;
		lane_n    = lane_c;
		rbc_n     = rbc_c;
		asm_n     = asm_c;
		push_c    = 1'b0;
		entry_c   = '0;
		case (phase_c)
			PH_HEADER: begin
				hshift_n = hs_new;
				if (pos_c == POS_OFFSET_LAST) begin
					offset_n = hs_new;
				end else if (pos_c == POS_WIDTH_LAST) begin
					width_n = hs_new[DIM_W-1:0];
					wbig_n  = hs_new > 32'(MAX_WIDTH);
				end else if (pos_c == POS_HEIGHT_LAST) begin
					height_n = hs_new[DIM_W-1:0];
					hbig_n   = hs_new > 32'(MAX_HEIGHT);
				end else if (pos_c == POS_DEPTH_LAST) begin
					if (size_bad) begin
						push_c         = 1'b1;
						entry_c.status = ST_TOO_BIG;
					end else if (!depth_ok) begin
						push_c         = 1'b1;
						entry_c.status = ST_BAD_DEPTH;
					end else begin
						depth32_n = (bpp == BPP_32);
					end
				end else if (pos_c == POS_HEADER_LAST) begin
					row_n  = height_c - 1'b1;
					col_n  = '0;
					lane_n = '0;
					rbc_n  = '0;
					asm_n  = '0;
				end
			end
			PH_SKIP, PH_PIXEL: begin
				if (in_pixel) begin
					rbc_n = rbc_c + 2'd1;
					if (pix_done) begin
						push_c             = 1'b1;
						entry_c.status     = ST_PIXEL;
						entry_c.row        = row_c;
						entry_c.col        = col_c;
						entry_c.width      = width_c;
						entry_c.value      = asm_new;
						entry_c.lane_mask  = depth32_c ? MASK_32 : MASK_24;
						entry_c.last_pixel = last;
						lane_n             = '0;
						asm_n              = '0;
						if (row_end) begin
							col_n = '0;
							if (row_c != '0) row_n = row_c - 1'b1;
						end else begin
							col_n = col_inc[DIM_W-1:0];
						end
					end else if (!pad) begin
						lane_n = lane_c + 2'd1;
						asm_n  = asm_new;
					end
				end
			end
			default: push_c = 1'b0;
		endcase
	end

	assign push.valid = accept && push_c;
	assign push.entry = entry_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hshift_q  <= '0;
			offset_q  <= '0;
			width_q   <= '0;
			height_q  <= '0;
			wbig_q    <= 1'b0;
			hbig_q    <= 1'b0;
			depth32_q <= 1'b0;
			phase_q   <= PH_HEADER;
			row_q     <= '0;
			col_q     <= '0;
			lane_q    <= '0;
			rbc_q     <= '0;
			asm_q     <= '0;
		end else if (accept) begin
			pos_q     <= pos_n;
			hshift_q  <= hshift_n;
			offset_q  <= offset_n;
			width_q   <= width_n;
			height_q  <= height_n;
			wbig_q    <= wbig_n;
			hbig_q    <= hbig_n;
			depth32_q <= depth32_n;
			phase_q   <= phase_n;
			row_q     <= row_n;
			col_q     <= col_n;
			lane_q    <= lane_n;
			rbc_q     <= rbc_n;
			asm_q     <= asm_n;
		end
	end

endmodule

// File: hw/rtl/bmpd_queue.sv
// ----------------------------------------------------------------------------
// bmpd_queue: request queue between parser and output stage
// Small FIFO that lets the parser keep taking bytes while results wait.
// ----------------------------------------------------------------------------
module bmpd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  bmpd_pkg::push_t push,
	output logic            full,
	output bmpd_pkg::head_t head,
	input  logic            pop
);
	import bmpd_pkg::*;

	qentry_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full          = (count_q == QCNT_W'(QDEPTH));
	assign head.nonempty = (count_q != '0);
	assign head.entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/bmpd_back.sv
// ----------------------------------------------------------------------------
// bmpd_back: index computation and output register
// Pops one request per cycle while one waits and the output register is free or
// not stalled, forms row*width+col and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module bmpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bmpd_pkg::head_t     head,
	output logic                pop,
	output logic                pixel_valid,
	input  logic                pixel_stall,
	output bmpd_pkg::out_item_t pixel_data
);
	import bmpd_pkg::*;

	logic                 valid_q;
	out_item_t            data_q;
	logic [2*DIM_W-1:0]   prod;
	logic [2*DIM_W:0]     sum;

	assign pop  = head.nonempty && (!valid_q || !pixel_stall);
	assign prod = head.entry.row * head.entry.width;
	assign sum  = {1'b0, prod} + (2*DIM_W+1)'(head.entry.col);

	assign pixel_valid = valid_q;
	assign pixel_data  = data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.status      <= head.entry.status;
			data_q.pixel_index <= IDX_W'(sum);
			data_q.pixel_value <= head.entry.value;
			data_q.lane_mask   <= head.entry.lane_mask;
			data_q.last_pixel  <= head.entry.last_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!pixel_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/bmpd_checker.sv
// ----------------------------------------------------------------------------
// bmpd_checker: port-level checks on the decoder results
// Watches the result channel and checks hold under stall and result shapes.
// ----------------------------------------------------------------------------
module bmpd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pixel_valid,
	input logic                pixel_stall,
	input bmpd_pkg::out_item_t pixel_data
);
	import bmpd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_data))
		else $error("result changed while stalled");

	a_error_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && (pixel_data.status != ST_PIXEL) |->
			(pixel_data.pixel_index == '0) && (pixel_data.pixel_value == '0) &&
			(pixel_data.lane_mask == '0) && !pixel_data.last_pixel)
		else $error("error result carries pixel fields");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && (pixel_data.status == ST_PIXEL) |->
			(pixel_data.lane_mask == MASK_32) || (pixel_data.lane_mask == MASK_24))
		else $error("pixel write with bad lane mask");

	a_lane3: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && (pixel_data.status == ST_PIXEL) &&
		(pixel_data.lane_mask == MASK_24) |-> (pixel_data.pixel_value[31:24] == 8'h00))
		else $error("unwritten lane not zero");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (pixel_data.status == ST_PIXEL) ||
			(pixel_data.status == ST_BAD_DEPTH) || (pixel_data.status == ST_TOO_BIG))
		else $error("undefined status code");

endmodule

bind bmp_stream_pixel_decoder bmpd_checker u_bmpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.pixel_data  (pixel_data)
);
